// ----- hw/rtl/redline_limit_monitor_macros.svh -----
// Assertion helpers for the redline limit monitor.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef REDLINE_LIMIT_MONITOR_MACROS_SVH
`define REDLINE_LIMIT_MONITOR_MACROS_SVH

// Same-cycle implication.
`define RLM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("redline limit monitor assertion failed");

// Next-cycle implication.
`define RLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("redline limit monitor assertion failed");

`endif

// ----- hw/rtl/rlm_pkg.sv -----
`timescale 1ns / 1ps

package rlm_pkg;

  // Table and store sizes.
  localparam int NUM_ENTRIES  = 16;
  localparam int NUM_CHANNELS = 32;
  localparam int EN_AW        = $clog2(NUM_ENTRIES);
  localparam int CH_AW        = $clog2(NUM_CHANNELS);

  // Latched abort index while nothing has been violated.
  localparam logic [7:0] NO_ABORT_INDEX = 8'hFE;

  // Configuration register indexes.
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_TEST_RUNNING   = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_LIMITS_ENABLED = 1'b1;

  // Input transaction kinds; code 3 is unused and ignored.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_EVAL   = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  sample_channel;
    logic [15:0] sample_value;
    logic [3:0]  entry_index;
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [4:0]  watched_channel;
    logic [15:0] lower_limit;
    logic [15:0] upper_limit;
    logic [31:0] eval_time;
  } in_item_t;

  typedef struct packed {
    logic       abort_now;
    logic [7:0] abort_entry;
    logic       heater_on;
  } out_item_t;

  // One limit table row as stored in the entry memory.
  typedef struct packed {
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [4:0]  channel;
    logic [15:0] lim_min;
    logic [15:0] lim_max;
  } entry_rec_t;

  localparam int ENTRY_WIDTH = $bits(entry_rec_t);

  // Contents of a row that has never been written.
  localparam entry_rec_t ENTRY_RESET = '{
    win_start: 32'h0000_0000,
    win_end:   32'hFFFF_FFFF,
    channel:   5'd0,
    lim_min:   16'd0,
    lim_max:   16'd0
  };

  // Evaluation sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } seq_state_t;

endpackage

// ----- hw/rtl/rlm_ram.sv -----
`timescale 1ns / 1ps

module rlm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/redline_limit_monitor.sv -----
`timescale 1ns / 1ps
// Writes: a sample or entry write is stored on acceptance, one write per cycle while the
// sequencer is idle. An evaluation walks entry rows 1 to NUM_ENTRIES - 1 during a test with
// limits on and row 0 alone otherwise, one row a cycle, feeding a registered channel store read;
// it then drains the pipeline and holds the input until its result is loaded for output.
// Reset (synchronous, rst_n low) clears the row and slot valid bits, so every entry and
// channel reads its reset value at once; no clearing pass is needed.
`include "redline_limit_monitor_macros.svh"

module redline_limit_monitor import rlm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic              cfg_wdata
);

  seq_state_t state_r, state_nxt;

  logic test_running_r;
  logic limits_enabled_r;

  logic in_accept;
  logic chan_we, ent_we, eval_start;
  logic [CH_AW-1:0] chan_waddr;
  logic [EN_AW-1:0] ent_waddr;
  entry_rec_t ent_wdata;

  logic [NUM_CHANNELS-1:0] chan_vld_r;
  logic [NUM_ENTRIES-1:0]  ent_vld_r;

  logic             mode_test_r;
  logic [31:0]      eval_time_r;
  logic [EN_AW-1:0] idx_r, idx_nxt;
  logic             issue, issue_last;

  logic             ent_hit_r;
  logic [ENTRY_WIDTH-1:0] ent_rdata;
  entry_rec_t       s1_ent;
  logic             s1_vld_r;
  logic [EN_AW-1:0] s1_idx_r;
  logic [CH_AW-1:0] chan_raddr;
  logic             s1_win, s1_chok;

  logic             s2_vld_r;
  logic [EN_AW-1:0] s2_idx_r;
  logic             s2_win_r, s2_chok_r;
  logic [15:0]      s2_min_r, s2_max_r;
  logic             chan_hit_r;
  logic [15:0]      chan_rdata;
  logic [15:0]      s2_value;
  logic             s2_viol;

  logic       abort_acc_r;
  logic [7:0] latched_abort_r;
  logic       heater_r;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      result_load;

  // Configuration registers; the user must write them only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_running_r   <= 1'b0;
      limits_enabled_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEST_RUNNING:   test_running_r   <= cfg_wdata;
        CFG_LIMITS_ENABLED: limits_enabled_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input handshake: a transaction is taken only while the sequencer is idle.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Decode the accepted transaction.
  always_comb begin
    chan_we    = 1'b0;
    ent_we     = 1'b0;
    eval_start = 1'b0;
    case (opcode_t'(in_data.opcode))
      OP_SAMPLE: chan_we    = in_accept && (32'(in_data.sample_channel) < NUM_CHANNELS);
      OP_ENTRY:  ent_we     = in_accept && (32'(in_data.entry_index) < NUM_ENTRIES);
      OP_EVAL:   eval_start = in_accept;
      default: ;
    endcase
  end

  assign chan_waddr = CH_AW'(in_data.sample_channel);
  assign ent_waddr  = EN_AW'(in_data.entry_index);
  assign ent_wdata  = '{
    win_start: in_data.window_start,
    win_end:   in_data.window_end,
    channel:   in_data.watched_channel,
    lim_min:   in_data.lower_limit,
    lim_max:   in_data.upper_limit
  };

  // Valid bits: a row or slot that was never written reads its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_vld_r <= '0;
      ent_vld_r  <= '0;
    end else begin
      if (chan_we) begin
        chan_vld_r[chan_waddr] <= 1'b1;
      end
      if (ent_we) begin
        ent_vld_r[ent_waddr] <= 1'b1;
      end
    end
  end

  // Limit table: one row per entry.
  rlm_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(NUM_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .re   (issue),
    .raddr(idx_r),
    .rdata(ent_rdata)
  );

  // Channel sample store.
  rlm_ram #(
    .WIDTH(16),
    .DEPTH(NUM_CHANNELS)
  ) u_chan_ram (
    .clk  (clk),
    .we   (chan_we),
    .waddr(chan_waddr),
    .wdata(in_data.sample_value),
    .re   (s1_vld_r),
    .raddr(chan_raddr),
    .rdata(chan_rdata)
  );

  // Sequencer: walk issues one row a cycle, drain lets the pipeline empty.
  assign issue      = (state_r == ST_WALK);
  assign issue_last = !mode_test_r || (idx_r == EN_AW'(NUM_ENTRIES - 1));
  assign result_load = (state_r == ST_RESULT) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (eval_start) begin
          state_nxt = ST_WALK;
          idx_nxt   = (test_running_r && limits_enabled_r) ? EN_AW'(1) : '0;
        end
      end
      ST_WALK: begin
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + EN_AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (result_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Per-evaluation context.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (eval_start) begin
      mode_test_r <= test_running_r && limits_enabled_r;
      eval_time_r <= in_data.eval_time;
    end
  end

  // Stage 1: table row arrives; check the window and start the channel read.
  assign s1_ent     = ent_hit_r ? entry_rec_t'(ent_rdata) : ENTRY_RESET;
  assign s1_win     = (s1_ent.win_start <= eval_time_r) && (s1_ent.win_end > eval_time_r);
  assign s1_chok    = (32'(s1_ent.channel) < NUM_CHANNELS);
  assign chan_raddr = CH_AW'(s1_ent.channel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ent_hit_r <= ent_vld_r[idx_r];
      s1_idx_r  <= idx_r;
    end
    if (s1_vld_r) begin
      chan_hit_r <= chan_vld_r[chan_raddr];
      s2_idx_r   <= s1_idx_r;
      s2_win_r   <= s1_win;
      s2_chok_r  <= s1_chok;
      s2_min_r   <= s1_ent.lim_min;
      s2_max_r   <= s1_ent.lim_max;
    end
  end

  // Stage 2: channel value arrives; compare against the limits.
  assign s2_value = (s2_chok_r && chan_hit_r) ? chan_rdata : 16'd0;
  assign s2_viol  = (s2_min_r > s2_value) || (s2_max_r < s2_value);

  // Abort latch and heater hysteresis. Rows come in rising order, so the
  // last violation seen is the highest index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abort_acc_r     <= 1'b0;
      latched_abort_r <= NO_ABORT_INDEX;
      heater_r        <= 1'b0;
    end else begin
      if (eval_start) begin
        abort_acc_r <= 1'b0;
      end
      if (s2_vld_r) begin
        if (mode_test_r) begin
          if (s2_win_r && s2_viol) begin
            abort_acc_r     <= 1'b1;
            latched_abort_r <= 8'(s2_idx_r);
          end
        end else if (s2_min_r > s2_value) begin
          heater_r <= 1'b1;
        end else if (s2_max_r < s2_value) begin
          heater_r <= 1'b0;
        end
      end
    end
  end

  // Output register: holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_data_r.abort_now   <= abort_acc_r;
      out_data_r.abort_entry <= latched_abort_r;
      out_data_r.heater_on   <= heater_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the stored state.
  `RLM_ASSERT_IMPL(pipe_only_in_walk, s1_vld_r || s2_vld_r,
                   (state_r == ST_WALK) || (state_r == ST_DRAIN))
  `RLM_ASSERT_IMPL(result_pipe_empty, state_r == ST_RESULT, !s1_vld_r && !s2_vld_r)
  `RLM_ASSERT_NEXT(result_delivered, result_load, out_valid_r && (state_r == ST_IDLE))
  `RLM_ASSERT_IMPL(latched_in_range, latched_abort_r != NO_ABORT_INDEX,
                   (latched_abort_r != 8'd0) && (latched_abort_r < 8'(NUM_ENTRIES)))
  `RLM_ASSERT_NEXT(heater_only_by_eval, !(s2_vld_r && !mode_test_r), $stable(heater_r))

endmodule
